// ===== hdl/rhc_pkg.sv =====
// rhc_pkg: types and constants shared by the RGB to HSV/HSL converter.
// Used by rhc_front, rhc_div and rgb_to_hsv_hsl_converter_unit; no dependencies.
package rhc_pkg;

  localparam int CH_W        = 8;
  localparam int HUE_W       = 15;
  localparam int SAT_W       = 12;
  localparam int LVL_W       = 9;

  localparam int NUM_W       = 23;
  localparam int DEN_W       = 8;
  localparam int QUO_W       = 15;
  localparam int DIV_STAGES  = 5;
  localparam int BITS_PER_STAGE = QUO_W / DIV_STAGES;
  localparam int PIPE_DEPTH  = DIV_STAGES + 3;

  localparam logic [HUE_W-1:0] HUE_FULL      = 15'd23040;
  localparam logic [HUE_W-1:0] HUE_GREEN_OFS = 15'd7680;
  localparam logic [HUE_W-1:0] HUE_BLUE_OFS  = 15'd15360;
  localparam logic signed [24:0] HUE_SCALE   = 25'sd3840;
  localparam logic [SAT_W-1:0] SAT_FULL      = 12'd4095;
  localparam logic [LVL_W-1:0] SUM_MID       = 9'd255;
  localparam logic [LVL_W-1:0] SUM_FULL      = 9'd510;

  typedef enum logic {
    MODE_HSV = 1'b0,
    MODE_HSL = 1'b1
  } rhc_mode_t;

  typedef enum logic [1:0] {
    SEC_RED   = 2'd0,
    SEC_GREEN = 2'd1,
    SEC_BLUE  = 2'd2
  } rhc_sector_t;

  typedef struct packed {
    logic [CH_W-1:0] red;
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] blue;
  } rhc_pixel_t;

  typedef struct packed {
    logic [HUE_W-1:0] hue;
    logic [SAT_W-1:0] saturation;
    logic [LVL_W-1:0] level;
  } rhc_hsx_t;

  typedef struct packed {
    logic [NUM_W-1:0] hue_num;
    logic [DEN_W-1:0] hue_den;
    logic [NUM_W-1:0] sat_num;
    logic [DEN_W-1:0] sat_den;
    logic [LVL_W-1:0] level;
  } rhc_div_req_t;

endpackage

// ===== hdl/rhc_front.sv =====
// rhc_front: two register stages that find max/min and sector, then build
// rounded numerators and denominators for hue and saturation. Uses rhc_pkg.
module rhc_front
  import rhc_pkg::*;
(
  input  logic         clk,
  input  logic [1:0]   en,
  input  rhc_mode_t    mode,
  input  rhc_pixel_t   pix,
  output rhc_div_req_t req
);

  logic signed [CH_W:0] x_r, x_nxt;
  logic [CH_W-1:0]      d_r, d_nxt;
  logic [CH_W-1:0]      mx_r, mx_nxt;
  logic [LVL_W-1:0]     sum_r, sum_nxt;
  logic [LVL_W-1:0]     lvl_r, lvl_nxt;
  rhc_sector_t          sec_r, sec_nxt;
  logic [CH_W-1:0]      mn;
  rhc_div_req_t         req_r, req_nxt;

  logic [HUE_W-1:0]     k;
  logic [NUM_W-1:0]     kd;
  logic signed [24:0]   x_ext;
  logic signed [24:0]   hnum;
  logic [DEN_W-1:0]     den_raw;
  logic [DEN_W-1:0]     sden;

  always_comb begin
    if (pix.red >= pix.green && pix.red >= pix.blue) begin
      sec_nxt = SEC_RED;
      mx_nxt  = pix.red;
      x_nxt   = $signed({1'b0, pix.green}) - $signed({1'b0, pix.blue});
    end else if (pix.green >= pix.blue) begin
      sec_nxt = SEC_GREEN;
      mx_nxt  = pix.green;
      x_nxt   = $signed({1'b0, pix.blue}) - $signed({1'b0, pix.red});
    end else begin
      sec_nxt = SEC_BLUE;
      mx_nxt  = pix.blue;
      x_nxt   = $signed({1'b0, pix.red}) - $signed({1'b0, pix.green});
    end
    mn = pix.red;
    if (pix.green < mn) mn = pix.green;
    if (pix.blue < mn) mn = pix.blue;
    d_nxt   = mx_nxt - mn;
    sum_nxt = {1'b0, mx_nxt} + {1'b0, mn};
    lvl_nxt = (mode == MODE_HSL) ? sum_nxt : {mx_nxt, 1'b0};
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      x_r   <= x_nxt;
      d_r   <= d_nxt;
      mx_r  <= mx_nxt;
      sum_r <= sum_nxt;
      lvl_r <= lvl_nxt;
      sec_r <= sec_nxt;
    end
  end

  always_comb begin
    case (sec_r)
      SEC_GREEN: k = HUE_GREEN_OFS;
      SEC_BLUE:  k = HUE_BLUE_OFS;
      default:   k = x_r[CH_W] ? HUE_FULL : '0;
    endcase
    kd    = NUM_W'(k) * NUM_W'(d_r);
    x_ext = {{(25-CH_W-1){x_r[CH_W]}}, x_r};
    hnum  = x_ext * HUE_SCALE + $signed({2'b00, kd})
          + $signed({{(25-CH_W+1){1'b0}}, d_r[CH_W-1:1]});

    if (mode == MODE_HSL) begin
      den_raw = (sum_r <= SUM_MID) ? sum_r[DEN_W-1:0] : DEN_W'(SUM_FULL - sum_r);
    end else begin
      den_raw = mx_r;
    end
    sden = (d_r == '0) ? DEN_W'(1) : den_raw;

    req_nxt.hue_num = hnum[NUM_W-1:0];
    req_nxt.hue_den = (d_r == '0) ? DEN_W'(1) : d_r;
    req_nxt.sat_num = NUM_W'(d_r) * NUM_W'(SAT_FULL) + NUM_W'(sden[DEN_W-1:1]);
    req_nxt.sat_den = sden;
    req_nxt.level   = lvl_r;
  end

  always_ff @(posedge clk) begin
    if (en[1]) begin
      req_r <= req_nxt;
    end
  end

  assign req = req_r;

endmodule

// ===== hdl/rhc_div.sv =====
// rhc_div: pipelined restoring divider, BITS_PER_STAGE (QUO_W / DIV_STAGES) quotient bits per stage.
// Quotient must fit QUO_W bits and the divisor must be nonzero. Uses rhc_pkg.
module rhc_div
  import rhc_pkg::*;
(
  input  logic                  clk,
  input  logic [DIV_STAGES-1:0] en,
  input  logic [NUM_W-1:0]      num,
  input  logic [DEN_W-1:0]      den,
  output logic [QUO_W-1:0]      quo
);

  typedef struct packed {
    logic [DEN_W-1:0] rem;
    logic [QUO_W-1:0] lo;
    logic [QUO_W-1:0] q;
    logic [DEN_W-1:0] den;
  } div_st_t;

  function automatic div_st_t div_step(input div_st_t st);
    div_st_t        s;
    logic [DEN_W:0] t;
    logic           ge;
    s = st;
    for (int i = 0; i < BITS_PER_STAGE; i++) begin
      t  = {s.rem, s.lo[QUO_W-1]};
      ge = (t >= {1'b0, s.den});
      s.rem = ge ? DEN_W'(t - {1'b0, s.den}) : t[DEN_W-1:0];
      s.lo  = {s.lo[QUO_W-2:0], 1'b0};
      s.q   = {s.q[QUO_W-2:0], ge};
    end
    return s;
  endfunction

  div_st_t st_in  [DIV_STAGES];
  div_st_t st_r   [DIV_STAGES];
  div_st_t st_nxt [DIV_STAGES];

  always_comb begin
    st_in[0].rem = num[NUM_W-1:QUO_W];
    st_in[0].lo  = num[QUO_W-1:0];
    st_in[0].q   = '0;
    st_in[0].den = den;
    for (int s = 1; s < DIV_STAGES; s++) begin
      st_in[s] = st_r[s-1];
    end
    for (int s = 0; s < DIV_STAGES; s++) begin
      st_nxt[s] = div_step(st_in[s]);
    end
  end

  always_ff @(posedge clk) begin
    for (int s = 0; s < DIV_STAGES; s++) begin
      if (en[s]) begin
        st_r[s] <= st_nxt[s];
      end
    end
  end

  assign quo = st_r[DIV_STAGES-1].q;

endmodule

// ===== hdl/rgb_to_hsv_hsl_converter_unit.sv =====
// RGB to HSV/HSL converter: one 8-bit RGB pixel in, hue (1/64 degree), saturation
// (4095 = 1.0) and level (2*max for HSV, max+min for HSL) out, all rounded to nearest.
// The block takes one item per clock while out_stall is low; an item passes from accept to
// out_valid through two front stages, five stages of the pipelined divider (three quotient
// bits each) and the output register. Each stage advances on its own, so a stall on
// the output fills bubbles before it pushes back on in_stall. cfg_wr_data selects
// HSL when 1 and HSV when 0; write it only while no item is in flight.
// Depends on rhc_pkg, rhc_front and rhc_div.
module rgb_to_hsv_hsl_converter_unit
  import rhc_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  rhc_pixel_t in_data,
  output logic       out_valid,
  input  logic       out_stall,
  output rhc_hsx_t   out_data,
  input  logic       cfg_wr_en,
  input  logic       cfg_wr_data
);

  rhc_mode_t              mode_r;
  logic [PIPE_DEPTH-1:0]  v_r, v_nxt;
  logic [PIPE_DEPTH-1:0]  en;
  rhc_div_req_t           req;
  logic [QUO_W-1:0]       hue_q;
  logic [QUO_W-1:0]       sat_q;
  logic [LVL_W-1:0]       lvl_r [DIV_STAGES];
  rhc_hsx_t               out_r, out_nxt;
  logic                   in_acc;
  logic                   out_acc;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_HSV;
    end else if (cfg_wr_en) begin
      mode_r <= rhc_mode_t'(cfg_wr_data);
    end
  end

  always_comb begin
    en[PIPE_DEPTH-1] = !v_r[PIPE_DEPTH-1] || !out_stall;
    for (int k = PIPE_DEPTH - 2; k >= 0; k--) begin
      en[k] = !v_r[k] || en[k+1];
    end
    v_nxt[0] = en[0] ? in_valid : v_r[0];
    for (int k = 1; k < PIPE_DEPTH; k++) begin
      v_nxt[k] = en[k] ? v_r[k-1] : v_r[k];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= v_nxt;
    end
  end

  rhc_front u_front (
    .clk  (clk),
    .en   (en[1:0]),
    .mode (mode_r),
    .pix  (in_data),
    .req  (req)
  );

  rhc_div u_div_hue (
    .clk (clk),
    .en  (en[DIV_STAGES+1:2]),
    .num (req.hue_num),
    .den (req.hue_den),
    .quo (hue_q)
  );

  rhc_div u_div_sat (
    .clk (clk),
    .en  (en[DIV_STAGES+1:2]),
    .num (req.sat_num),
    .den (req.sat_den),
    .quo (sat_q)
  );

  always_ff @(posedge clk) begin
    if (en[2]) begin
      lvl_r[0] <= req.level;
    end
    for (int s = 1; s < DIV_STAGES; s++) begin
      if (en[s+2]) begin
        lvl_r[s] <= lvl_r[s-1];
      end
    end
  end

  always_comb begin
    out_nxt.hue        = (hue_q >= HUE_FULL) ? '0 : hue_q;
    out_nxt.saturation = sat_q[SAT_W-1:0];
    out_nxt.level      = lvl_r[DIV_STAGES-1];
  end

  always_ff @(posedge clk) begin
    if (en[PIPE_DEPTH-1]) begin
      out_r <= out_nxt;
    end
  end

  assign in_stall  = !en[0];
  assign out_valid = v_r[PIPE_DEPTH-1];
  assign out_data  = out_r;
  assign in_acc    = in_valid && !in_stall;
  assign out_acc   = out_valid && !out_stall;

  a_item_count: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |-> $countones(v_r) ==
      $countones($past(v_r)) + int'($past(in_acc)) - int'($past(out_acc)))
    else $error("item count in pipeline does not match accepts and deliveries");

  a_hue_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.hue < HUE_FULL)
    else $error("hue out of range");

  a_black: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.level == '0 |-> out_data.hue == '0 && out_data.saturation == '0)
    else $error("black pixel with nonzero hue or saturation");

  a_hsv_even: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && mode_r == MODE_HSV |-> out_data.level[0] == 1'b0)
    else $error("HSV level is not twice the max channel");

endmodule

// ===== bench/tb_top.sv =====
// tb_top: self-checking bench for rgb_to_hsv_hsl_converter_unit, HSV and HSL modes.
// Walks a directed pixel table, then random pixels, in all but one phase under random
// idling on both sides; checks table values or in-bench conversions; uses rhc_pkg.
module tb_top;
  import rhc_pkg::*;

  localparam int LIMIT_CYCLES = 200000;
  localparam int PHASE_ITEMS  = 150;
  localparam int NUM_PHASES   = 6;

  typedef struct {
    rhc_mode_t  mode;
    rhc_pixel_t px;
    bit         known;
    rhc_hsx_t   hsx;
  } pixel_row_t;

  typedef struct {
    bit       known;
    rhc_hsx_t hsx;
  } typed_hsx_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_stall;
  rhc_pixel_t in_data = '0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  rhc_hsx_t   out_data;
  logic       cfg_wr_en = 1'b0;
  logic       cfg_wr_data = 1'b0;

  rhc_mode_t  model_mode = MODE_HSV;
  rhc_mode_t  drive_mode = MODE_HSV;
  bit         steady = 1'b0;
  int         cycle_count = 0;
  int         error_count = 0;
  int         checked_count = 0;
  int         sent_count = 0;
  int         directed_count = 0;

  typed_hsx_t typed_q[$];
  rhc_hsx_t   hsx_q[$];
  pixel_row_t pixel_tab[$];

  rgb_to_hsv_hsl_converter_unit dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  always #10 clk = ~clk;

  function automatic int unsigned round_half_up(int unsigned num, int unsigned den);
    return (2 * num + den) / (2 * den);
  endfunction

  function automatic rhc_hsx_t convert_pixel(rhc_pixel_t px, rhc_mode_t mode);
    int r, g, b, mx, mn, d, num, sum, den;
    int unsigned hue, sat, lvl;
    rhc_hsx_t res;
    r = px.red;
    g = px.green;
    b = px.blue;
    mx = r;
    mn = r;
    if (g > mx) mx = g;
    if (b > mx) mx = b;
    if (g < mn) mn = g;
    if (b < mn) mn = b;
    d = mx - mn;
    hue = 0;
    sat = 0;
    if (d > 0) begin
      if (mx == r) num = 3840 * (g - b);
      else if (mx == g) num = 3840 * (b - r) + 7680 * d;
      else num = 3840 * (r - g) + 15360 * d;
      if (num < 0) num += 23040 * d;
      hue = round_half_up(num, d);
      if (hue >= 23040) hue = 0;
    end
    if (mode == MODE_HSV) begin
      lvl = 2 * mx;
      if (d > 0) sat = round_half_up(4095 * d, mx);
    end else begin
      sum = mx + mn;
      lvl = sum;
      if (d > 0) begin
        den = (sum <= 255) ? sum : 510 - sum;
        sat = round_half_up(4095 * d, den);
      end
    end
    res.hue = HUE_W'(hue);
    res.saturation = SAT_W'(sat);
    res.level = LVL_W'(lvl);
    return res;
  endfunction

  function automatic pixel_row_t pixel_row(rhc_mode_t mode, int r, int g, int b, bit known,
                                           int h = 0, int s = 0, int l = 0);
    pixel_row_t row;
    row.mode = mode;
    row.px = '{red: CH_W'(r), green: CH_W'(g), blue: CH_W'(b)};
    row.known = known;
    row.hsx = '{hue: HUE_W'(h), saturation: SAT_W'(s), level: LVL_W'(l)};
    return row;
  endfunction

  function automatic logic [CH_W-1:0] edge_level();
    case ($urandom_range(3))
      0: return 8'd0;
      1: return 8'd1;
      2: return 8'd254;
      default: return 8'd255;
    endcase
  endfunction

  function automatic rhc_pixel_t random_pixel();
    rhc_pixel_t px;
    logic [CH_W-1:0] v;
    px = (3 * CH_W)'($urandom);
    v = CH_W'($urandom);
    case ($urandom_range(9))
      0: px = '{red: v, green: v, blue: v};
      1: px = '{red: edge_level(), green: edge_level(), blue: edge_level()};
      2: px.green = px.red;
      3: px.blue = px.green;
      4: px.blue = px.red;
      5: px.blue = (px.green > 0) ? px.green - CH_W'(1) : px.green;
      default: ;
    endcase
    return px;
  endfunction

  task automatic send_pixel(rhc_pixel_t px, bit known, rhc_hsx_t hsx);
    while (!steady && $urandom_range(99) < 18) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    typed_q.push_back('{known: known, hsx: hsx});
    in_valid <= 1'b1;
    in_data <= px;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sent_count++;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (hsx_q.size() != 0 || typed_q.size() != 0) @(posedge clk);
  endtask

  task automatic set_mode(rhc_mode_t mode);
    drain();
    repeat (PIPE_DEPTH + 2) @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= mode;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    drive_mode = mode;
  endtask

  always @(posedge clk) begin
    out_stall <= !steady && ($urandom_range(99) < 18);
  end

  always @(posedge clk) begin
    typed_hsx_t t;
    rhc_hsx_t want;
    if (rst_n && cfg_wr_en) model_mode <= rhc_mode_t'(cfg_wr_data);
    if (rst_n && in_valid && !in_stall) begin
      t = typed_q.pop_front();
      hsx_q.push_back(t.known ? t.hsx : convert_pixel(in_data, model_mode));
    end
    if (rst_n && out_valid && !out_stall) begin
      if (hsx_q.size() == 0) begin
        $error("unexpected item: hue=%0d saturation=%0d level=%0d",
               out_data.hue, out_data.saturation, out_data.level);
        error_count++;
      end else begin
        want = hsx_q.pop_front();
        checked_count++;
        if (out_data.hue !== want.hue) begin
          $error("hue: expected %0d, actual %0d", want.hue, out_data.hue);
          error_count++;
        end
        if (out_data.saturation !== want.saturation) begin
          $error("saturation: expected %0d, actual %0d", want.saturation, out_data.saturation);
          error_count++;
        end
        if (out_data.level !== want.level) begin
          $error("level: expected %0d, actual %0d", want.level, out_data.level);
          error_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("Timeout after %0d cycles, %0d items still expected", cycle_count, hsx_q.size());
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial begin
    pixel_tab.push_back(pixel_row(MODE_HSV,   0,   0,   0, 1, 0,     0,    0));
    pixel_tab.push_back(pixel_row(MODE_HSV, 255, 255, 255, 1, 0,     0,    510));
    pixel_tab.push_back(pixel_row(MODE_HSV, 255,   0,   0, 1, 0,     4095, 510));
    pixel_tab.push_back(pixel_row(MODE_HSV,   0, 255,   0, 1, 7680,  4095, 510));
    pixel_tab.push_back(pixel_row(MODE_HSV,   0,   0, 255, 1, 15360, 4095, 510));
    pixel_tab.push_back(pixel_row(MODE_HSV, 128, 128, 128, 1, 0,     0,    256));
    pixel_tab.push_back(pixel_row(MODE_HSV,   1,   0,   0, 1, 0,     4095, 2));
    pixel_tab.push_back(pixel_row(MODE_HSV, 255,   0, 255, 0));
    pixel_tab.push_back(pixel_row(MODE_HSV, 255, 255,   0, 0));
    pixel_tab.push_back(pixel_row(MODE_HSV,   0, 255, 255, 0));
    pixel_tab.push_back(pixel_row(MODE_HSV, 255,   0,   1, 0));
    pixel_tab.push_back(pixel_row(MODE_HSV, 255, 254, 254, 0));
    pixel_tab.push_back(pixel_row(MODE_HSV,  10,  20,  30, 0));
    pixel_tab.push_back(pixel_row(MODE_HSL,   0,   0,   0, 1, 0,     0,    0));
    pixel_tab.push_back(pixel_row(MODE_HSL, 255, 255, 255, 1, 0,     0,    510));
    pixel_tab.push_back(pixel_row(MODE_HSL, 255,   0,   0, 1, 0,     4095, 255));
    pixel_tab.push_back(pixel_row(MODE_HSL, 128, 128, 128, 1, 0,     0,    256));
    pixel_tab.push_back(pixel_row(MODE_HSL,   1,   0,   0, 1, 0,     4095, 1));
    pixel_tab.push_back(pixel_row(MODE_HSL, 255, 254, 254, 1, 0,     4095, 509));
    pixel_tab.push_back(pixel_row(MODE_HSL, 255, 255,   1, 0));
    pixel_tab.push_back(pixel_row(MODE_HSL, 200, 100,  50, 0));
    pixel_tab.push_back(pixel_row(MODE_HSL,   0, 255, 255, 0));
    pixel_tab.push_back(pixel_row(MODE_HSL,   0,   1,   0, 0));
    pixel_tab.push_back(pixel_row(MODE_HSL,   0,   0,   1, 0));

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (pixel_tab[i]) begin
      if (pixel_tab[i].mode != drive_mode) set_mode(pixel_tab[i].mode);
      send_pixel(pixel_tab[i].px, pixel_tab[i].known, pixel_tab[i].hsx);
    end
    directed_count = sent_count;

    for (int p = 0; p < NUM_PHASES; p++) begin
      set_mode((p % 2 == 0) ? MODE_HSV : MODE_HSL);
      steady = (p == 2);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (p == 3 && n == PHASE_ITEMS / 2) drain();
        send_pixel(random_pixel(), 1'b0, '0);
      end
    end

    drain();
    steady = 1'b0;
    repeat (PIPE_DEPTH * 4) @(posedge clk);

    $display("Sent %0d pixels (%0d directed) in HSV and HSL modes; %0d results checked",
             sent_count, directed_count, checked_count);
    $display("Covered greys, ties, channel extremes, idle gaps and output stalls");
    if (error_count == 0 && hsx_q.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
hdl/rhc_pkg.sv
hdl/rhc_front.sv
hdl/rhc_div.sv
hdl/rgb_to_hsv_hsl_converter_unit.sv
bench/tb_top.sv
